// ===== rtl/core/cbti_pkg.sv =====
// Shared types, constants and codes for the clipped bilinear table interpolator.
package cbti_pkg;

    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_MAX_ROWS = 16;
    localparam int CNT_W = 5;
    localparam int IDX_OUT_W = 4;
    localparam int FRAC_W = 16;

    localparam logic [1:0] KIND_COL_BP = 2'd0;
    localparam logic [1:0] KIND_ROW_BP = 2'd1;
    localparam logic [1:0] KIND_TABLE = 2'd2;
    localparam logic [1:0] KIND_LOOKUP = 2'd3;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] entry_addr;
        logic signed [31:0] write_data;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
    } item_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0] col_index;
        logic [3:0] row_index;
        logic [15:0] col_frac;
        logic [15:0] row_frac;
    } item_out_t;

    typedef enum logic [3:0] {
        OP_IDLE = 4'd0,
        OP_LOAD = 4'd1,
        OP_EDGE = 4'd2,
        OP_STEP = 4'd3,
        OP_DIVI = 4'd4,
        OP_DSTP = 4'd5,
        OP_FETCH = 4'd6,
        OP_MUL = 4'd7,
        OP_DONE = 4'd8,
        OP_ZERO = 4'd9,
        OP_RDEC = 4'd10
    } op_t;

    typedef struct packed {
        op_t op;
        logic axis;
        logic [1:0] sub;
    } cmd_t;

    typedef struct packed {
        logic clipped;
        logic search_done;
        logic div_done;
        logic zero_size;
    } stat_t;

endpackage

// ===== rtl/core/cbti_ram.sv =====
// Generic single-port RAM with registered read.
module cbti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/cbti_ctrl.sv =====
// Controller state machine sequencing a lookup through the datapath.
module cbti_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  cbti_pkg::stat_t stat,
    output cbti_pkg::cmd_t cmd,
    output logic busy,
    output logic done
);
    import cbti_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ZERO  = 11'b00000000010,
        S_LOAD  = 11'b00000000100,
        S_EDGE  = 11'b00000001000,
        S_STEP  = 11'b00000010000,
        S_DIVI  = 11'b00000100000,
        S_DSTP  = 11'b00001000000,
        S_FETCH = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_RDEC  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic axis_reg, axis_next;
    logic [1:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= 1'b0;
            sub_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            sub_reg <= sub_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next = axis_reg;
        sub_next = sub_reg;
        cmd.op = OP_IDLE;
        cmd.axis = axis_reg;
        cmd.sub = sub_reg;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                axis_next = 1'b0;
                sub_next = 2'd0;
                if (go)
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.op = OP_ZERO;
                state_next = stat.zero_size ? S_FETCH : S_LOAD;
            end
            S_LOAD:
            begin
                // first read of the end breakpoints is in flight
                cmd.op = OP_LOAD;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                begin
                    sub_next = 2'd0;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                cmd.op = OP_EDGE;
                state_next = stat.clipped ? S_RDEC : S_STEP;
            end
            S_STEP:
            begin
                cmd.op = OP_STEP;
                if (stat.search_done)
                begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                cmd.op = OP_DIVI;
                state_next = S_DSTP;
            end
            S_DSTP:
            begin
                cmd.op = OP_DSTP;
                if (stat.div_done)
                begin
                    state_next = S_RDEC;
                end
            end
            S_RDEC:
            begin
                cmd.op = OP_RDEC;
                if (axis_reg)
                begin
                    axis_next = 1'b0;
                    state_next = S_FETCH;
                end
                else
                begin
                    axis_next = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_FETCH:
            begin
                // four table reads, one address per cycle plus read latency
                cmd.op = OP_FETCH;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    sub_next = 2'd0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.op = OP_DONE;
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

// ===== rtl/core/cbti_dp.sv =====
// Datapath: breakpoint and table stores, search, divider and blend unit.
module cbti_dp #(
    parameter int MAX_COLS = cbti_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = cbti_pkg::DEF_MAX_ROWS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic take,
    input  cbti_pkg::item_in_t item_in,
    input  logic [cbti_pkg::CNT_W-1:0] cols_in_use,
    input  logic [cbti_pkg::CNT_W-1:0] rows_in_use,
    input  cbti_pkg::cmd_t cmd,
    output cbti_pkg::stat_t stat,
    output cbti_pkg::item_out_t item_out
);
    import cbti_pkg::*;

    localparam int CA_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int TA_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = (CA_W > RA_W) ? CA_W + 1 : RA_W + 1;
    localparam int NW = (IW > CNT_W) ? IW : CNT_W;

    // held lookup operands
    logic signed [31:0] x_reg, y_reg;
    logic [NW-1:0] nc_reg, nr_reg;
    logic zero_reg;

    // search state for the current axis
    logic [IW-1:0] lo_reg, hi_reg, lo_next, hi_next;
    logic [IW-1:0] col_lo_reg, col_hi_reg, row_lo_reg, row_hi_reg;
    logic [FRAC_W-1:0] col_frac_reg, row_frac_reg;
    logic signed [31:0] blo_reg;
    logic [1:0] phase_reg;
    logic clip_reg;

    // divider
    logic [32:0] num_reg, den_reg;
    logic [33:0] rem_reg;
    logic [16:0] quo_reg;
    logic [4:0] dcnt_reg;
    logic dskip_reg;

    // blend
    logic signed [31:0] e_reg [4];
    logic signed [33:0] acc0_reg, acc1_reg, res_reg;

    logic signed [31:0] xv;
    logic [NW-1:0] nn;
    logic [IW-1:0] mid;

    assign xv = cmd.axis ? y_reg : x_reg;
    assign nn = cmd.axis ? nr_reg : nc_reg;
    assign mid = IW'((({1'b0, lo_reg}) + ({1'b0, hi_reg})) >> 1);

    // breakpoint RAM addressing
    logic [IW-1:0] bp_idx;
    logic cbp_we, rbp_we;
    logic signed [31:0] cbp_q, rbp_q, bp_q;
    logic [CA_W-1:0] cbp_a;
    logic [RA_W-1:0] rbp_a;

    always_comb
    begin
        bp_idx = mid;
        if (cmd.op == OP_LOAD || cmd.op == OP_ZERO || cmd.op == OP_RDEC)
        begin
            bp_idx = (cmd.sub == 2'd0 && cmd.op == OP_LOAD) ? '0 : IW'(nn - 1'b1);
        end
        if (cmd.op == OP_RDEC || cmd.op == OP_ZERO)
        begin
            bp_idx = IW'(nc_reg - 1'b1);
        end
        if (cmd.op == OP_STEP && phase_reg == 2'd2)
        begin
            bp_idx = lo_reg;
        end
        if (cmd.op == OP_STEP && phase_reg == 2'd3)
        begin
            bp_idx = hi_reg;
        end
    end

    assign cbp_we = wr_en && item_in.kind == KIND_COL_BP && item_in.entry_addr < MAX_COLS;
    assign rbp_we = wr_en && item_in.kind == KIND_ROW_BP && item_in.entry_addr < MAX_ROWS;
    assign cbp_a = wr_en ? CA_W'(item_in.entry_addr) : CA_W'(bp_idx);
    assign rbp_a = wr_en ? RA_W'(item_in.entry_addr) : RA_W'(bp_idx);
    assign bp_q = cmd.axis ? rbp_q : cbp_q;

    cbti_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_cbp (
        .clk(clk), .we(cbp_we), .addr(cbp_a), .wdata(item_in.write_data), .rdata(cbp_q)
    );
    cbti_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_rbp (
        .clk(clk), .we(rbp_we), .addr(rbp_a), .wdata(item_in.write_data), .rdata(rbp_q)
    );

    // table RAM: entry index row*nc+col, one corner per fetch cycle
    logic [TA_W-1:0] tab_a;
    logic tab_we;
    logic signed [31:0] tab_q;
    logic [IW-1:0] cidx, ridx;
    logic [2*NW-1:0] lin;

    always_comb
    begin
        cidx = cmd.sub[0] ? col_hi_reg : col_lo_reg;
        ridx = cmd.sub[1] ? row_hi_reg : row_lo_reg;
        if (zero_reg)
        begin
            cidx = '0;
            ridx = '0;
        end
        lin = (2*NW)'(ridx) * (2*NW)'(nc_reg) + (2*NW)'(cidx);
    end

    // row*nc+col stays below nc*nr, so it always fits the store
    assign tab_we = wr_en && item_in.kind == KIND_TABLE && item_in.entry_addr < DEPTH;
    assign tab_a = wr_en ? TA_W'(item_in.entry_addr) : TA_W'(lin);

    cbti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tab (
        .clk(clk), .we(tab_we), .addr(tab_a), .wdata(item_in.write_data), .rdata(tab_q)
    );

    // search control
    logic sdone;
    assign sdone = (phase_reg == 2'd3) && (cmd.op == OP_STEP);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (bp_q > xv)
        begin
            hi_next = mid;
        end
        else
        begin
            lo_next = mid;
        end
    end

    logic signed [33:0] prod_a, prod_b;
    logic [15:0] mfrac;
    logic signed [50:0] prod;
    assign prod = prod_b * $signed({1'b0, mfrac});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            clip_reg <= 1'b0;
            zero_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                x_reg <= item_in.x_in;
                y_reg <= item_in.y_in;
                nc_reg <= (cols_in_use > MAX_COLS) ? NW'(MAX_COLS) : NW'(cols_in_use);
                nr_reg <= (rows_in_use > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_in_use);
                col_lo_reg <= '0;
                col_hi_reg <= '0;
                row_lo_reg <= '0;
                row_hi_reg <= '0;
                col_frac_reg <= '0;
                row_frac_reg <= '0;
            end
            case (cmd.op)
                OP_ZERO:
                begin
                    zero_reg <= (nc_reg == '0) || (nr_reg == '0);
                end
                OP_LOAD:
                begin
                    // sub 0 requests bp[0]; sub 1 requests bp[n-1], captures bp[0]
                    if (cmd.sub == 2'd1)
                    begin
                        blo_reg <= bp_q;
                    end
                    lo_reg <= '0;
                    hi_reg <= IW'(nn - 1'b1);
                    phase_reg <= 2'd0;
                end
                OP_EDGE:
                begin
                    clip_reg <= (xv >= bp_q) || (xv <= blo_reg);
                    if (xv >= bp_q)
                    begin
                        lo_reg <= IW'(nn - 1'b1);
                        hi_reg <= IW'(nn - 1'b1);
                    end
                    else if (xv <= blo_reg)
                    begin
                        lo_reg <= '0;
                        hi_reg <= '0;
                    end
                    phase_reg <= 2'd0;
                end
                OP_STEP:
                begin
                    // phase 0: issue mid read; 1: compare; 2/3: fetch bp[lo], bp[hi]
                    case (phase_reg)
                        2'd0:
                        begin
                            phase_reg <= (hi_reg - lo_reg > 1) ? 2'd1 : 2'd2;
                        end
                        2'd1:
                        begin
                            lo_reg <= lo_next;
                            hi_reg <= hi_next;
                            phase_reg <= 2'd0;
                        end
                        2'd2:
                        begin
                            phase_reg <= 2'd3;
                        end
                        default:
                        begin
                            blo_reg <= bp_q;
                            phase_reg <= 2'd0;
                        end
                    endcase
                end
                OP_DIVI:
                begin
                    num_reg <= {xv[31], xv} - {blo_reg[31], blo_reg};
                    den_reg <= {bp_q[31], bp_q} - {blo_reg[31], blo_reg};
                    dskip_reg <= ($signed({xv[31], xv}) - $signed({blo_reg[31], blo_reg}) <= 0)
                              || ($signed({bp_q[31], bp_q}) - $signed({blo_reg[31], blo_reg}) <= 0);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dcnt_reg <= '0;
                end
                OP_DSTP:
                begin
                    // restoring division of num*65536 by den, one quotient bit per cycle
                    if (dcnt_reg < 5'd17)
                    begin
                        if (dcnt_reg == 5'd0)
                        begin
                            rem_reg <= {1'b0, num_reg} >= {1'b0, den_reg}
                                ? {1'b0, num_reg} - {1'b0, den_reg} : {1'b0, num_reg};
                            quo_reg <= {16'd0, ({1'b0, num_reg} >= {1'b0, den_reg})};
                        end
                        else if ({rem_reg[32:0], 1'b0} >= {1'b0, den_reg})
                        begin
                            rem_reg <= {rem_reg[32:0], 1'b0} - {1'b0, den_reg};
                            quo_reg <= {quo_reg[15:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[32:0], 1'b0};
                            quo_reg <= {quo_reg[15:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg + 5'd1;
                    end
                end
                OP_RDEC:
                begin
                    if (cmd.axis)
                    begin
                        row_lo_reg <= lo_reg;
                        row_hi_reg <= hi_reg;
                        row_frac_reg <= clip_reg ? '0 : (dskip_reg ? '0
                            : (quo_reg[16] ? 16'hFFFF : quo_reg[15:0]));
                    end
                    else
                    begin
                        col_lo_reg <= lo_reg;
                        col_hi_reg <= hi_reg;
                        col_frac_reg <= clip_reg ? '0 : (dskip_reg ? '0
                            : (quo_reg[16] ? 16'hFFFF : quo_reg[15:0]));
                    end
                    clip_reg <= 1'b0;
                end
                OP_FETCH:
                begin
                    if (cmd.sub != 2'd0)
                    begin
                        e_reg[cmd.sub - 2'd1] <= tab_q;
                    end
                end
                OP_MUL:
                begin
                    case (cmd.sub)
                        2'd0:
                        begin
                            e_reg[3] <= tab_q;
                        end
                        2'd1:
                        begin
                            acc0_reg <= prod_a + 34'(prod >>> 16);
                        end
                        2'd2:
                        begin
                            acc1_reg <= prod_a + 34'(prod >>> 16);
                        end
                        default:
                        begin
                            res_reg <= zero_reg ? 34'(e_reg[0]) : prod_a + 34'(prod >>> 16);
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // multiplier operand select: frac * (b - a), floor by arithmetic shift
    always_comb
    begin
        prod_a = 34'(e_reg[0]);
        prod_b = 34'(e_reg[1]) - 34'(e_reg[0]);
        mfrac = col_frac_reg;
        case (cmd.sub)
            2'd2:
            begin
                prod_a = 34'(e_reg[2]);
                prod_b = 34'(e_reg[3]) - 34'(e_reg[2]);
            end
            2'd3:
            begin
                prod_a = acc0_reg;
                prod_b = acc1_reg - acc0_reg;
                mfrac = row_frac_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.clipped = (xv >= bp_q) || (xv <= blo_reg);
    assign stat.search_done = sdone;
    assign stat.div_done = (dcnt_reg == 5'd17);
    assign stat.zero_size = (nc_reg == '0) || (nr_reg == '0);

    assign item_out.result_value = (res_reg > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF
        : (res_reg < -34'sh80000000) ? 32'sh80000000 : res_reg[31:0];
    assign item_out.col_index = 4'(col_lo_reg);
    assign item_out.row_index = 4'(row_lo_reg);
    assign item_out.col_frac = col_frac_reg;
    assign item_out.row_frac = row_frac_reg;
endmodule

// ===== rtl/core/clipped_bilinear_table_interp.sv =====
// Top level of the clipped bilinear table interpolator.
//  channel  | signals                          | handshake
//  item in  | start, busy, item_in             | taken when start && !busy
//  result   | done, result                     | one-cycle strobe, no stall
//  config   | psel penable pwrite paddr pwdata | write on access cycle
// A write item does not raise busy. A lookup holds busy for the zero-size check, the
// end loads of each axis, the search (up to four steps) and the 17-step divider of
// each inside axis, and the table fetch and blend; a zero size skips to the fetch.
// busy stays high until the result strobe; the receiver cannot stall results.
// Reset sets cols_in_use to 16, rows_in_use to 1; stores are not cleared.
module clipped_bilinear_table_interp #(
    parameter int MAX_COLS = cbti_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = cbti_pkg::DEF_MAX_ROWS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cbti_pkg::item_in_t item_in,
    output logic done,
    output cbti_pkg::item_out_t result,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import cbti_pkg::*;

    logic [CNT_W-1:0] cols_reg, rows_reg;
    logic take, look, wr_en, ctrl_busy;
    cmd_t cmd;
    stat_t stat;

    assign pready = 1'b1;
    assign take = start && !busy;
    assign look = take && item_in.kind == KIND_LOOKUP;
    assign wr_en = take && item_in.kind != KIND_LOOKUP;
    assign busy = ctrl_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CNT_W'(16);
            rows_reg <= CNT_W'(1);
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_COLS)
        begin
            cols_reg <= pwdata[CNT_W-1:0];
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_ROWS)
        begin
            rows_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows_reg) : 32'(cols_reg);

    cbti_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .go(look), .stat(stat),
        .cmd(cmd), .busy(ctrl_busy), .done(done)
    );

    cbti_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .take(look), .item_in(item_in),
        .cols_in_use(cols_reg), .rows_in_use(rows_reg), .cmd(cmd), .stat(stat),
        .item_out(result)
    );
endmodule

// ===== bench/tb_clipped_bilinear_table_interp.sv =====
// Self-checking testbench for the clipped bilinear table interpolator.
`timescale 1ns / 100ps

module tb_clipped_bilinear_table_interp;
    import cbti_pkg::*;

    localparam int NCOL = 16;
    localparam int NROW = 16;
    localparam int TDEPTH = NCOL * NROW;
    localparam int DRAIN_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};
    localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_in_t item_in = '0;
    logic done;
    item_out_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Interpolator shadow state
    logic signed [31:0] col_bp [NCOL];
    logic signed [31:0] row_bp [NROW];
    logic signed [31:0] grid [TDEPTH];
    logic [4:0] cols_cfg = 5'd16;
    logic [4:0] rows_cfg = 5'd1;

    item_out_t pending_results [$];
    int fail_count = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    longint cycle_count = 0;

    clipped_bilinear_table_interp DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item_in(item_in),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint floor_blend(longint a, longint b, logic [15:0] frac);
        longint prod;
        prod = longint'({1'b0, frac}) * (b - a);
        return a + (prod >>> 16);
    endfunction

    // Clip, then binary search for the bracketing pair and the Q0.16 fraction.
    function automatic void bracket(input logic signed [31:0] v, input bit on_rows,
                                    input int n, output int lo, output int hi,
                                    output logic [15:0] frac);
        int l;
        int h;
        int m;
        longint num;
        longint den;
        longint q;
        logic signed [31:0] bl;
        logic signed [31:0] bh;
        l = 0;
        h = n - 1;
        frac = '0;
        bh = on_rows ? row_bp[h] : col_bp[h];
        bl = on_rows ? row_bp[0] : col_bp[0];
        if (v >= bh)
        begin
            lo = h;
            hi = h;
            return;
        end
        if (v <= bl)
        begin
            lo = 0;
            hi = 0;
            return;
        end
        while (h - l > 1)
        begin
            m = (l + h) / 2;
            if ((on_rows ? row_bp[m] : col_bp[m]) > v)
                h = m;
            else
                l = m;
        end
        num = longint'(v) - longint'(on_rows ? row_bp[l] : col_bp[l]);
        den = longint'(on_rows ? row_bp[h] : col_bp[h])
            - longint'(on_rows ? row_bp[l] : col_bp[l]);
        if (den > 0 && num > 0)
        begin
            q = (num * 65536) / den;
            frac = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        lo = l;
        hi = h;
    endfunction

    function automatic item_out_t interpolate(item_in_t it);
        item_out_t r;
        int nc;
        int nr;
        int l1;
        int h1;
        int l2;
        int h2;
        logic [15:0] f1;
        logic [15:0] f2;
        longint r0;
        longint r1;
        longint v;
        nc = (cols_cfg > NCOL) ? NCOL : int'(cols_cfg);
        nr = (rows_cfg > NROW) ? NROW : int'(rows_cfg);
        r = '0;
        if (nc == 0 || nr == 0)
            v = grid[0];
        else
        begin
            bracket(it.x_in, 1'b0, nc, l1, h1, f1);
            bracket(it.y_in, 1'b1, nr, l2, h2, f2);
            r0 = floor_blend(grid[(l2 * nc + l1) % TDEPTH], grid[(l2 * nc + h1) % TDEPTH], f1);
            r1 = floor_blend(grid[(h2 * nc + l1) % TDEPTH], grid[(h2 * nc + h1) % TDEPTH], f1);
            v = floor_blend(r0, r1, f2);
            r.col_index = l1[3:0];
            r.row_index = l2[3:0];
            r.col_frac = f1;
            r.row_frac = f2;
        end
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        r.result_value = v[31:0];
        return r;
    endfunction

    function automatic void absorb_item(item_in_t it);
        case (it.kind)
            KIND_COL_BP: if (it.entry_addr < NCOL) col_bp[it.entry_addr] = it.write_data;
            KIND_ROW_BP: if (it.entry_addr < NROW) row_bp[it.entry_addr] = it.write_data;
            KIND_TABLE: grid[it.entry_addr] = it.write_data;
            default: pending_results.push_back(interpolate(it));
        endcase
    endfunction

    always @(posedge clk)
    begin
        item_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (mismatch_count < 10)
                    $display("ERROR: unexpected result %h", result);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.result_value !== want.result_value
                    || result.col_index !== want.col_index
                    || result.row_index !== want.row_index
                    || result.col_frac !== want.col_frac
                    || result.row_frac !== want.row_frac)
                begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("ERROR: value %h/%h col %h/%h row %h/%h cf %h/%h rf %h/%h",
                                 result.result_value, want.result_value,
                                 result.col_index, want.col_index,
                                 result.row_index, want.row_index,
                                 result.col_frac, want.col_frac,
                                 result.row_frac, want.row_frac);
                    mismatch_count++;
                end
            end
        end
    end

    // Enter and leave at a falling edge.
    task automatic send_item(item_in_t it);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_in = it;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        absorb_item(it);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_COLS)
            cols_cfg = data[4:0];
        else if (addr == ADDR_ROWS)
            rows_cfg = data[4:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic item_in_t make_item(logic [1:0] k, int addr, logic [31:0] d,
                                           logic [31:0] x, logic [31:0] y);
        item_in_t it;
        it.kind = k;
        it.entry_addr = addr[7:0];
        it.write_data = d;
        it.x_in = x;
        it.y_in = y;
        return it;
    endfunction

    task automatic load_breaks(bit fine);
        longint acc;
        acc = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
        for (int i = 0; i < NCOL; i++)
        begin
            send_item(make_item(KIND_COL_BP, i, acc[31:0], $urandom, $urandom));
            acc += fine ? $urandom_range(1, 4) : $urandom_range(1, 1 << 22);
        end
        acc = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
        for (int i = 0; i < NROW; i++)
        begin
            send_item(make_item(KIND_ROW_BP, i, acc[31:0], $urandom, $urandom));
            acc += fine ? $urandom_range(1, 4) : $urandom_range(1, 1 << 22);
        end
    endtask

    // Pick a coordinate: mostly inside an interval, sometimes on or past the ends.
    function automatic logic [31:0] pick_coord(bit on_rows, int n);
        int i;
        longint lo;
        longint hi;
        i = $urandom_range(0, (n > 1) ? n - 2 : 0);
        lo = on_rows ? row_bp[i] : col_bp[i];
        hi = on_rows ? row_bp[i + 1] : col_bp[i + 1];
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return lo[31:0];
            2: return on_rows ? row_bp[NROW - 1] : col_bp[NCOL - 1];
            default:
                if (hi > lo)
                    return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
                else
                    return lo[31:0];
        endcase
    endfunction

    task automatic test_fill_stores;
        load_breaks(1'b0);
        for (int i = 0; i < TDEPTH; i++)
            send_item(make_item(KIND_TABLE, i, $urandom, $urandom, $urandom));
    endtask

    task automatic test_directed;
        logic [31:0] edges [6];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, col_bp[0], col_bp[NCOL - 1],
                  col_bp[0] + 1, col_bp[NCOL - 1] - 1};
        foreach (edges[i])
            send_item(make_item(KIND_LOOKUP, 0, $urandom, edges[i], $urandom));
        // ignored writes beyond the breakpoint stores, then writes to the last and first table entries
        send_item(make_item(KIND_COL_BP, 255, 32'hFFFF_FFFF, 0, 0));
        send_item(make_item(KIND_ROW_BP, 16, 32'h8000_0000, 0, 0));
        send_item(make_item(KIND_TABLE, 255, 32'h7FFF_FFFF, 0, 0));
        send_item(make_item(KIND_TABLE, 0, 32'h8000_0000, 0, 0));
        drain();
        write_reg(ADDR_ROWS, 32'd16);
        send_item(make_item(KIND_LOOKUP, 8'hFF, 0, col_bp[3] + 7, row_bp[15]));
        send_item(make_item(KIND_LOOKUP, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(KIND_LOOKUP, 0, 0, col_bp[7], row_bp[8] + 3));
        drain();
    endtask

    task automatic test_sizes;
        logic [4:0] sizes [7];
        sizes = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd9};
        foreach (sizes[i])
        begin
            write_reg(ADDR_COLS, {27'd0, sizes[i]});
            write_reg(ADDR_ROWS, {27'd0, sizes[(i + 3) % 7]});
            for (int j = 0; j < 4; j++)
                send_item(make_item(KIND_LOOKUP, $urandom, $urandom,
                                    pick_coord(1'b0, NCOL), pick_coord(1'b1, NROW)));
            drain();
        end
    endtask

    task automatic test_random;
        int sent;
        int nc;
        int nr;
        sent = 0;
        while (sent < 1470)
        begin
            write_reg(ADDR_COLS, $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(2, 16));
            write_reg(ADDR_ROWS, $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 16));
            nc = (cols_cfg > NCOL) ? NCOL : cols_cfg;
            nr = (rows_cfg > NROW) ? NROW : rows_cfg;
            if ($urandom_range(0, 3) == 0)
            begin
                load_breaks($urandom_range(0, 2) == 0);
                sent += NCOL + NROW;
            end
            for (int j = 0; j < 60; j++)
            begin
                case ($urandom_range(0, 19))
                    0: send_item(make_item(KIND_COL_BP, $urandom, $urandom, $urandom, $urandom));
                    1: send_item(make_item(KIND_ROW_BP, $urandom, $urandom, $urandom, $urandom));
                    2, 3: send_item(make_item(KIND_TABLE, $urandom, $urandom, $urandom, $urandom));
                    default: send_item(make_item(KIND_LOOKUP, $urandom, $urandom,
                                                 pick_coord(1'b0, nc), pick_coord(1'b1, nr)));
                endcase
                sent++;
            end
            drain();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_fill_stores();
        test_directed();
        test_sizes();
        test_random();
        drain();
        fail_count += pending_results.size();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
